[design/srcu_pkg.sv]
// Shared types and constants for the sparse reduced-cost update block.
// Used by the front, queue, back, top level and checker; no dependencies.
`timescale 1ns / 1ps

package srcu_pkg;

   // Command codes on the request channel
   localparam logic [1:0] CMD_LOAD  = 2'd0;
   localparam logic [1:0] CMD_APPLY = 2'd1;
   localparam logic [1:0] CMD_READ  = 2'd2;

   // Widths fixed by the request and register fields
   localparam int unsigned LIMIT_W   = 13;
   localparam int unsigned COL_W     = 16;
   localparam int unsigned IDX_W     = 16;
   localparam int unsigned CMP_W     = 17;
   localparam int unsigned DATA_W    = 32;
   localparam int unsigned PROD_W    = 64;
   localparam int unsigned RND_W     = 48;
   localparam int unsigned DIFF_W    = 49;
   localparam int unsigned ROUND_POS = 16;

   localparam logic [LIMIT_W-1:0] LIMIT_RESET = 13'd4096;

   // Queue between front and back
   localparam int unsigned QUEUE_DEPTH = 2;
   localparam int unsigned QPTR_W      = 1;
   localparam int unsigned QCNT_W      = 2;

   typedef enum logic [1:0] {
      KIND_LOAD,
      KIND_APPLY,
      KIND_READ
   } kind_type;

   // One classified operation handed from front to back
   typedef struct packed {
      kind_type                  kind;
      logic                      hit;
      logic [IDX_W-1:0]          idx;
      logic signed [DATA_W-1:0]  value;
      logic signed [DATA_W-1:0]  dual;
   } op_type;

   typedef struct packed {
      logic full;
      logic empty;
   } q_status_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_EXEC,
      ST_ROUND,
      ST_WRITE
   } state_type;

endpackage

[design/srcu_queue.sv]
// Two-entry operation queue between the front and the back.
// Depends on srcu_pkg for the operation and status types.
`timescale 1ns / 1ps

module srcu_queue
   import srcu_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         push,
   input  op_type       push_op,
   input  logic         pop,
   output op_type       head_op,
   output q_status_type status
);

   op_type              entries_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0]   wr_ptr_ff;
   logic [QPTR_W-1:0]   rd_ptr_ff;
   logic [QCNT_W-1:0]   count_ff;
   logic [QCNT_W-1:0]   count_in;

   // Track fill level
   always_comb begin
      count_in = count_ff;
      if (push && !pop) begin
         count_in = count_ff + QCNT_W'(1);
      end else if (pop && !push) begin
         count_in = count_ff - QCNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         count_ff <= count_in;
         if (push) begin
            wr_ptr_ff <= wr_ptr_ff + QPTR_W'(1);
         end
         if (pop) begin
            rd_ptr_ff <= rd_ptr_ff + QPTR_W'(1);
         end
      end
   end

   // Store pushed entries
   always_ff @(posedge clock) begin
      if (push) begin
         entries_ff[wr_ptr_ff] <= push_op;
      end
   end

   assign head_op      = entries_ff[rd_ptr_ff];
   assign status.full  = (count_ff == QCNT_W'(QUEUE_DEPTH));
   assign status.empty = (count_ff == '0);

endmodule

[design/srcu_front.sv]
// Front end: takes requests, holds the column limit, checks the column and
// dual, and pushes useful operations into the queue. Depends on srcu_pkg.
`timescale 1ns / 1ps

module srcu_front
   import srcu_pkg::*;
#(
   parameter int unsigned MAX_COLUMNS = 4096
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   output logic                      req_stall,
   input  logic [1:0]                req_cmd,
   input  logic signed [COL_W-1:0]   req_column,
   input  logic signed [DATA_W-1:0]  req_value,
   input  logic signed [DATA_W-1:0]  req_dual,
   input  logic                      csr_valid,
   output logic                      csr_ready,
   input  logic [LIMIT_W-1:0]        csr_data,
   input  q_status_type              q_status,
   output logic                      push,
   output op_type                    push_op
);

   localparam logic [CMP_W-1:0] MAX_LIM = CMP_W'(MAX_COLUMNS);

   logic [LIMIT_W-1:0] column_limit_ff;
   logic [CMP_W-1:0]   lim_eff;
   logic [CMP_W-1:0]   col_u;
   logic               hit;
   logic               dual_pos;
   logic               keep;

   // Hold the column limit register
   always_ff @(posedge clock) begin
      if (reset) begin
         column_limit_ff <= LIMIT_RESET;
      end else if (csr_valid && csr_ready) begin
         column_limit_ff <= csr_data;
      end
   end

   assign csr_ready = 1'b1;
   assign req_stall = q_status.full;

   // Classify the column and the dual
   always_comb begin
      lim_eff  = CMP_W'(column_limit_ff);
      if (lim_eff > MAX_LIM) begin
         lim_eff = MAX_LIM;
      end
      col_u    = {2'b00, req_column[COL_W-2:0]};
      hit      = !req_column[COL_W-1] && (col_u < lim_eff);
      dual_pos = !req_dual[DATA_W-1] && (req_dual != '0);
   end

   // Drop operations that leave no trace; reads always go through
   always_comb begin
      push_op.hit   = hit;
      push_op.idx   = col_u[IDX_W-1:0];
      push_op.value = req_value;
      push_op.dual  = req_dual;
      push_op.kind  = KIND_READ;
      keep          = 1'b0;
      case (req_cmd)
         CMD_LOAD: begin
            push_op.kind = KIND_LOAD;
            keep         = hit;
         end
         CMD_APPLY: begin
            push_op.kind = KIND_APPLY;
            keep         = hit && dual_pos;
         end
         CMD_READ: begin
            push_op.kind = KIND_READ;
            keep         = 1'b1;
         end
         default: begin
            keep = 1'b0;
         end
      endcase
   end

   assign push = req_valid && !req_stall && keep;

endmodule

[design/srcu_back.sv]
// Back end: cost store, multiply-round-subtract sequencer and response
// register. Depends on srcu_pkg for the operation and state types.
`timescale 1ns / 1ps

module srcu_back
   import srcu_pkg::*;
#(
   parameter int unsigned MAX_COLUMNS = 4096
) (
   input  logic                      clock,
   input  logic                      reset,
   input  q_status_type              q_status,
   input  op_type                    head_op,
   output logic                      pop,
   output logic                      rsp_valid,
   input  logic                      rsp_stall,
   output logic signed [DATA_W-1:0]  rsp_reduced_cost,
   output logic                      rsp_column_valid
);

   localparam int unsigned ADDR_W = (MAX_COLUMNS > 1) ? $clog2(MAX_COLUMNS) : 1;

   localparam logic signed [DIFF_W-1:0] SAT_MAX = DIFF_W'(signed'(32'sh7fffffff));
   localparam logic signed [DIFF_W-1:0] SAT_MIN = -DIFF_W'(signed'(33'sh080000000));

   logic [DATA_W-1:0]        cost_mem [MAX_COLUMNS];
   logic [DATA_W-1:0]        rdata_ff;

   state_type                state_ff;
   state_type                state_in;
   op_type                   op_ff;
   logic signed [PROD_W-1:0] prod_ff;
   logic signed [PROD_W-1:0] prod_in;
   logic signed [PROD_W-1:0] rsum;
   logic signed [RND_W-1:0]  rnd_ff;
   logic signed [DIFF_W-1:0] diff;
   logic signed [DATA_W-1:0] sat;

   logic                     rd_en;
   logic                     wr_en;
   logic [DATA_W-1:0]        wdata;
   logic [ADDR_W-1:0]        addr;
   logic                     rsp_load;
   logic                     rsp_valid_ff;
   logic signed [DATA_W-1:0] rsp_cost_ff;
   logic                     rsp_col_ff;

   assign addr = op_ff.idx[ADDR_W-1:0];

   // Arithmetic: product, rounding to Q16.16, saturated difference
   always_comb begin
      prod_in = PROD_W'(op_ff.dual) * PROD_W'(op_ff.value);
      rsum    = prod_ff + PROD_W'(32768);
      diff    = DIFF_W'(signed'(rdata_ff)) - DIFF_W'(rnd_ff);
      if (diff > SAT_MAX) begin
         sat = 32'sh7fffffff;
      end else if (diff < SAT_MIN) begin
         sat = 32'sh80000000;
      end else begin
         sat = diff[DATA_W-1:0];
      end
   end

   // Sequence one operation at a time
   always_comb begin
      state_in = state_ff;
      pop      = 1'b0;
      rd_en    = 1'b0;
      wr_en    = 1'b0;
      wdata    = sat;
      rsp_load = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            if (!q_status.empty) begin
               pop      = 1'b1;
               state_in = ST_EXEC;
            end
         end
         ST_EXEC: begin
            if (op_ff.kind == KIND_LOAD) begin
               wr_en    = 1'b1;
               wdata    = op_ff.value;
               state_in = ST_IDLE;
            end else begin
               rd_en    = op_ff.hit;
               state_in = ST_ROUND;
            end
         end
         ST_ROUND: begin
            if (op_ff.kind == KIND_APPLY) begin
               state_in = ST_WRITE;
            end else if (!rsp_valid_ff || !rsp_stall) begin
               rsp_load = 1'b1;
               state_in = ST_IDLE;
            end
         end
         ST_WRITE: begin
            wr_en    = 1'b1;
            state_in = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // Latch the popped operation and advance the arithmetic registers
   always_ff @(posedge clock) begin
      if (pop) begin
         op_ff <= head_op;
      end
      prod_ff <= prod_in;
      rnd_ff  <= rsum[PROD_W-1:ROUND_POS];
   end

   // Cost store with registered read
   always_ff @(posedge clock) begin
      if (wr_en) begin
         cost_mem[addr] <= wdata;
      end
      if (rd_en) begin
         rdata_ff <= cost_mem[addr];
      end
   end

   // Response register: hold while stalled
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (rsp_load) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (rsp_load) begin
         rsp_cost_ff <= op_ff.hit ? signed'(rdata_ff) : '0;
         rsp_col_ff  <= op_ff.hit;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_reduced_cost = rsp_cost_ff;
   assign rsp_column_valid = rsp_col_ff;

endmodule

[design/sparse_reduced_cost_update_top.sv]
// Sparse reduced-cost update (s = c - A^T u), top level.
// Usage:
//   Request channel (req_valid / req_stall): cmd 0 loads a Q16.16 cost into
//   a column, cmd 1 applies one matrix nonzero (cost -= round(dual * value),
//   saturated, only for dual > 0), cmd 2 reads a column, cmd 3 is ignored.
//   Columns outside 0 .. min(limit, MAX_COLUMNS)-1 are ignored; a read of
//   such a column answers zero with column_valid low.
//   Response channel (rsp_valid / rsp_stall): one response per read, in order.
//   CSR channel (csr_valid / csr_ready): writes the 13-bit column limit;
//   csr_ready is always high. Write it only while the block is idle.
// Timing: the front classifies and queues a request in the accept cycle.
//   The back runs one operation at a time, in steps set by the single-port
//   cost store and the one multiplier: a load pops and writes; an apply
//   pops, multiplies and reads the store, rounds, writes back; a read pops,
//   reads the store, loads the response. Ignored requests are not queued.
//   A two-entry queue lets the front accept while the back works.
// Reset: synchronous, clears control state and sets the limit to 4096; the
//   cost store holds garbage until each column is loaded.
// A stalled response holds; the back waits in its round step until the
//   response register frees, and the queue then fills and raises req_stall.
`timescale 1ns / 1ps

module sparse_reduced_cost_update_top
   import srcu_pkg::*;
#(
   parameter int unsigned MAX_COLUMNS = 4096
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   output logic                      req_stall,
   input  logic [1:0]                req_cmd,
   input  logic signed [COL_W-1:0]   req_column,
   input  logic signed [DATA_W-1:0]  req_value,
   input  logic signed [DATA_W-1:0]  req_dual,
   output logic                      rsp_valid,
   input  logic                      rsp_stall,
   output logic signed [DATA_W-1:0]  rsp_reduced_cost,
   output logic                      rsp_column_valid,
   input  logic                      csr_valid,
   output logic                      csr_ready,
   input  logic [LIMIT_W-1:0]        csr_data
);

   q_status_type q_status;
   logic         push;
   logic         pop;
   op_type       push_op;
   op_type       head_op;

   // Accept and classify
   srcu_front #(
      .MAX_COLUMNS (MAX_COLUMNS)
   ) u_front (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_stall  (req_stall),
      .req_cmd    (req_cmd),
      .req_column (req_column),
      .req_value  (req_value),
      .req_dual   (req_dual),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_data   (csr_data),
      .q_status   (q_status),
      .push       (push),
      .push_op    (push_op)
   );

   // Decouple front and back
   srcu_queue u_queue (
      .clock   (clock),
      .reset   (reset),
      .push    (push),
      .push_op (push_op),
      .pop     (pop),
      .head_op (head_op),
      .status  (q_status)
   );

   // Execute against the cost store
   srcu_back #(
      .MAX_COLUMNS (MAX_COLUMNS)
   ) u_back (
      .clock            (clock),
      .reset            (reset),
      .q_status         (q_status),
      .head_op          (head_op),
      .pop              (pop),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_reduced_cost (rsp_reduced_cost),
      .rsp_column_valid (rsp_column_valid)
   );

endmodule

[design/srcu_checker.sv]
// Port-level checker for the sparse reduced-cost update top level, with its
// bind statement. Depends on srcu_pkg for the data width.
`timescale 1ns / 1ps

module srcu_checker
   import srcu_pkg::*;
(
   input logic                      clock,
   input logic                      reset,
   input logic                      req_valid,
   input logic                      req_stall,
   input logic [1:0]                req_cmd,
   input logic                      rsp_valid,
   input logic                      rsp_stall,
   input logic signed [DATA_W-1:0]  rsp_reduced_cost,
   input logic                      rsp_column_valid
);

   // No response right after reset
   a_reset_clears: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("response valid after reset");

   // Stalled response stays up
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid)
      else $error("response dropped while stalled");

   // Stalled payload holds
   a_rsp_stable: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> $stable(rsp_reduced_cost) && $stable(rsp_column_valid))
      else $error("response payload changed while stalled");

   // Out-of-range column answers zero
   a_invalid_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_column_valid |-> rsp_reduced_cost == '0)
      else $error("invalid column with nonzero cost");

   // Stalled request holds
   a_req_hold: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_stall |=> req_valid && $stable(req_cmd))
      else $error("request dropped or changed while stalled");

endmodule

bind sparse_reduced_cost_update_top srcu_checker u_checker (
   .clock            (clock),
   .reset            (reset),
   .req_valid        (req_valid),
   .req_stall        (req_stall),
   .req_cmd          (req_cmd),
   .rsp_valid        (rsp_valid),
   .rsp_stall        (rsp_stall),
   .rsp_reduced_cost (rsp_reduced_cost),
   .rsp_column_valid (rsp_column_valid)
);
